@@ hdl/eeprom_emulation_on_mirrored_flash_top_defines.svh @@
// Assertion macros for the mirrored-flash EEPROM emulation block.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef EEPROM_EMULATION_ON_MIRRORED_FLASH_TOP_DEFINES_SVH
`define EEPROM_EMULATION_ON_MIRRORED_FLASH_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EEMF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define EEMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EEMF_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define EEMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/eemf_pkg.sv @@
// Shared types and constants of the mirrored-flash EEPROM emulation block.
// No dependencies.
`default_nettype none
package eemf_pkg;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_MOUNT = 2'd2;

    localparam logic [15:0] HDR_ERASED = 16'hFFFF;
    localparam logic [15:0] HDR_VALID  = 16'hF0F0;
    localparam logic [7:0]  BYTE_TAG   = 8'hFF;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] address;
        logic [7:0] write_data;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
        logic       relocated;
        logic       last;
    } t_out;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLR, DP_LOAD, DP_SET_ERR, DP_DIV_STEP, DP_RD_CELL,
        DP_CAP_RDATA, DP_WR_CELL, DP_RD_DHDR, DP_ERASE_INIT_DST,
        DP_ERASE_INIT_SRC, DP_ERASE_INIT_MNT, DP_ERASE_STEP, DP_COPY_INIT,
        DP_COPY_RS, DP_COPY_RD, DP_COPY_WR, DP_COPY_NEXT, DP_DHDR_WR,
        DP_REMAP, DP_MNT_UNMAP, DP_MNT_RD, DP_MNT_MAP, DP_MNT_NEXTM,
        DP_MNT_CLAIM, DP_MNT_NEXTP
    } t_dp_op;

    typedef struct packed {
        logic clr_last;
        logic oor;
        logic rem_ge;
        logic map_ok;
        logic is_write;
        logic q_eq_din;
        logic q_erased;
        logic q_valid;
        logic copy_diff;
        logic tries_end;
        logic erase_last;
        logic off_last;
        logic off_skip;
        logic m_last;
        logic p_last;
        logic found;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RANGE, S_DIV, S_RD_ISSUE, S_RD_CAP, S_WR_ISSUE,
        S_WR_EVAL, S_RL_HDR, S_RL_HDR_EV, S_ERASE, S_CP_INIT, S_CP_CHK,
        S_CP_RS, S_CP_RD, S_CP_EV, S_CP_NEXT, S_RL_VALID, S_RL_ESRC,
        S_RL_REMAP, S_MNT_PAGE, S_MNT_RD, S_MNT_EV, S_MNT_NEXTM, S_MNT_END,
        S_MNT_NEXTP, S_DONE
    } t_state;

endpackage
`default_nettype wire

@@ hdl/eemf_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module eemf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ hdl/eemf_dp.sv @@
// Datapath: flash array, page map, address split, copy and erase counters.
// Depends on eemf_pkg and eemf_ram.
`default_nettype none
module eemf_dp #(
    parameter int PAGE_HALFWORDS = 512,
    parameter int PAGES          = 2,
    parameter int MIRRORS        = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire eemf_pkg::t_dp_op i_op,
    input  wire eemf_pkg::t_in    i_item,
    output eemf_pkg::t_dp_stat    o_stat,
    output eemf_pkg::t_out        o_res
);
    localparam int DC    = PAGE_HALFWORDS - 1;
    localparam int CELLS = MIRRORS * PAGES * PAGE_HALFWORDS;
    localparam int LIMIT = PAGES * DC;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int MW    = $clog2(MIRRORS);
    localparam int OW    = $clog2(PAGE_HALFWORDS);
    localparam int TW    = $clog2(MIRRORS + 2);

    logic [1:0]    r_func;
    logic [9:0]    r_rem;
    logic [7:0]    r_wdata;
    logic [PW-1:0] r_page;
    logic [TW-1:0] r_tries;
    logic [MW-1:0] r_mm;
    logic          r_found;
    logic [MW-1:0] r_em;
    logic [OW-1:0] r_ecnt;
    logic [OW-1:0] r_coff;
    logic [15:0]   r_cdin;
    logic [AW-1:0] r_ccnt;
    logic          r_map_v [PAGES];
    logic [MW-1:0] r_map_m [PAGES];
    eemf_pkg::t_out r_res;

    logic [MW-1:0] map_m;
    logic [MW-1:0] newm;
    logic [OW-1:0] off;
    logic [15:0]   din_w;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_wdata;
    logic [15:0]   ram_q;

    function automatic logic [AW-1:0] cell_addr(input logic [MW-1:0] m,
                                                input logic [PW-1:0] p,
                                                input logic [OW-1:0] o);
        cell_addr = AW'((int'(m) * PAGES + int'(p)) * PAGE_HALFWORDS + int'(o));
    endfunction

    assign map_m = r_map_m[r_page];
    assign newm  = (map_m == MW'(MIRRORS - 1)) ? '0 : map_m + MW'(1);
    assign off   = OW'(r_rem + 10'd1);
    assign din_w = {eemf_pkg::BYTE_TAG, r_wdata};

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = cell_addr(map_m, r_page, off);
        ram_wdata = din_w;
        case (i_op)
            eemf_pkg::DP_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = r_ccnt;
                ram_wdata = eemf_pkg::HDR_ERASED;
            end
            eemf_pkg::DP_WR_CELL: begin
                ram_we = 1'b1;
            end
            eemf_pkg::DP_RD_DHDR: begin
                ram_addr = cell_addr(newm, r_page, '0);
            end
            eemf_pkg::DP_ERASE_STEP: begin
                ram_we    = 1'b1;
                ram_addr  = cell_addr(r_em, r_page, r_ecnt);
                ram_wdata = eemf_pkg::HDR_ERASED;
            end
            eemf_pkg::DP_COPY_RS: begin
                ram_addr = cell_addr(map_m, r_page, r_coff);
            end
            eemf_pkg::DP_COPY_RD: begin
                ram_addr = cell_addr(newm, r_page, r_coff);
            end
            eemf_pkg::DP_COPY_WR: begin
                ram_we    = 1'b1;
                ram_addr  = cell_addr(newm, r_page, r_coff);
                ram_wdata = r_cdin;
            end
            eemf_pkg::DP_DHDR_WR: begin
                ram_we    = 1'b1;
                ram_addr  = cell_addr(newm, r_page, '0);
                ram_wdata = eemf_pkg::HDR_VALID;
            end
            eemf_pkg::DP_MNT_RD: begin
                ram_addr = cell_addr(r_mm, r_page, '0);
            end
            eemf_pkg::DP_MNT_CLAIM: begin
                ram_we    = 1'b1;
                ram_addr  = cell_addr('0, r_page, '0);
                ram_wdata = eemf_pkg::HDR_VALID;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    eemf_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_flash (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
            for (int i = 0; i < PAGES; i++) begin
                r_map_v[i] <= 1'b0;
            end
        end else begin
            case (i_op)
                eemf_pkg::DP_CLR: begin
                    r_ccnt <= r_ccnt + AW'(1);
                end
                eemf_pkg::DP_LOAD: begin
                    r_func    <= i_item.func;
                    r_rem     <= i_item.address;
                    r_wdata   <= i_item.write_data;
                    r_page    <= '0;
                    r_tries   <= '0;
                    r_res     <= '{read_data: 8'd0, status: 1'b0, relocated: 1'b0,
                                   last: i_item.last_byte};
                end
                eemf_pkg::DP_SET_ERR: begin
                    r_res.status <= 1'b1;
                end
                eemf_pkg::DP_DIV_STEP: begin
                    r_rem  <= r_rem - 10'(DC);
                    r_page <= r_page + PW'(1);
                end
                eemf_pkg::DP_CAP_RDATA: begin
                    r_res.read_data <= ram_q[7:0];
                end
                eemf_pkg::DP_ERASE_INIT_DST: begin
                    r_em   <= newm;
                    r_ecnt <= '0;
                end
                eemf_pkg::DP_ERASE_INIT_SRC: begin
                    r_em   <= map_m;
                    r_ecnt <= '0;
                end
                eemf_pkg::DP_ERASE_INIT_MNT: begin
                    r_em   <= r_mm;
                    r_ecnt <= '0;
                end
                eemf_pkg::DP_ERASE_STEP: begin
                    r_ecnt <= r_ecnt + OW'(1);
                end
                eemf_pkg::DP_COPY_INIT: begin
                    r_coff <= OW'(1);
                end
                eemf_pkg::DP_COPY_RD: begin
                    r_cdin <= {eemf_pkg::BYTE_TAG, ram_q[7:0]};
                end
                eemf_pkg::DP_COPY_NEXT: begin
                    r_coff <= r_coff + OW'(1);
                end
                eemf_pkg::DP_REMAP: begin
                    r_map_m[r_page] <= newm;
                    r_res.relocated <= 1'b1;
                    r_tries         <= r_tries + TW'(1);
                end
                eemf_pkg::DP_MNT_UNMAP: begin
                    r_map_v[r_page] <= 1'b0;
                    r_mm            <= '0;
                    r_found         <= 1'b0;
                end
                eemf_pkg::DP_MNT_MAP: begin
                    r_map_v[r_page] <= 1'b1;
                    r_map_m[r_page] <= r_mm;
                    r_found         <= 1'b1;
                end
                eemf_pkg::DP_MNT_NEXTM: begin
                    r_mm <= r_mm + MW'(1);
                end
                eemf_pkg::DP_MNT_CLAIM: begin
                    r_map_v[r_page] <= 1'b1;
                    r_map_m[r_page] <= '0;
                end
                eemf_pkg::DP_MNT_NEXTP: begin
                    r_page <= r_page + PW'(1);
                end
                default: begin
                    r_ccnt <= r_ccnt;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_ccnt == AW'(CELLS - 1));
        o_stat.oor        = ({22'd0, r_rem} >= 32'(LIMIT));
        o_stat.rem_ge     = ({22'd0, r_rem} >= 32'(DC));
        o_stat.map_ok     = r_map_v[r_page];
        o_stat.is_write   = (r_func == eemf_pkg::FUNC_WRITE);
        o_stat.q_eq_din   = (ram_q == din_w);
        o_stat.q_erased   = (ram_q == eemf_pkg::HDR_ERASED);
        o_stat.q_valid    = (ram_q == eemf_pkg::HDR_VALID);
        o_stat.copy_diff  = (r_cdin != ram_q);
        o_stat.tries_end  = (r_tries == TW'(MIRRORS + 1));
        o_stat.erase_last = (r_ecnt == OW'(PAGE_HALFWORDS - 1));
        o_stat.off_last   = (r_coff == OW'(PAGE_HALFWORDS - 1));
        o_stat.off_skip   = (r_coff == off);
        o_stat.m_last     = (r_mm == MW'(MIRRORS - 1));
        o_stat.p_last     = (r_page == PW'(PAGES - 1));
        o_stat.found      = r_found;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

@@ hdl/eemf_ctrl.sv @@
// Controller state machine: sequences reads, writes, relocation and mount.
// Depends on eemf_pkg and the assertion macro header.
`default_nettype none
`include "eeprom_emulation_on_mirrored_flash_top_defines.svh"
module eemf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_func,
    input  wire eemf_pkg::t_dp_stat i_stat,
    output eemf_pkg::t_dp_op        o_op,
    output logic                    o_busy,
    output logic                    o_valid
);
    eemf_pkg::t_state r_state, n_state;
    eemf_pkg::t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eemf_pkg::S_CLEAR;
            r_ret   <= eemf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            eemf_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = eemf_pkg::S_IDLE;
            end
            eemf_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_func == eemf_pkg::FUNC_MOUNT) n_state = eemf_pkg::S_MNT_PAGE;
                    else if (i_func == eemf_pkg::FUNC_READ || i_func == eemf_pkg::FUNC_WRITE)
                        n_state = eemf_pkg::S_RANGE;
                    else n_state = eemf_pkg::S_DONE;
                end
            end
            eemf_pkg::S_RANGE: begin
                n_state = i_stat.oor ? eemf_pkg::S_DONE : eemf_pkg::S_DIV;
            end
            eemf_pkg::S_DIV: begin
                if (!i_stat.rem_ge) begin
                    if (!i_stat.map_ok) n_state = eemf_pkg::S_DONE;
                    else if (i_stat.is_write) n_state = eemf_pkg::S_WR_ISSUE;
                    else n_state = eemf_pkg::S_RD_ISSUE;
                end
            end
            eemf_pkg::S_RD_ISSUE: n_state = eemf_pkg::S_RD_CAP;
            eemf_pkg::S_RD_CAP:   n_state = eemf_pkg::S_DONE;
            eemf_pkg::S_WR_ISSUE: n_state = eemf_pkg::S_WR_EVAL;
            eemf_pkg::S_WR_EVAL: begin
                if (i_stat.q_eq_din || i_stat.q_erased) n_state = eemf_pkg::S_DONE;
                else n_state = eemf_pkg::S_RL_HDR;
            end
            eemf_pkg::S_RL_HDR: n_state = eemf_pkg::S_RL_HDR_EV;
            eemf_pkg::S_RL_HDR_EV: begin
                if (!i_stat.q_erased) begin
                    n_state = eemf_pkg::S_ERASE;
                    n_ret   = eemf_pkg::S_CP_INIT;
                end else begin
                    n_state = eemf_pkg::S_CP_INIT;
                end
            end
            eemf_pkg::S_ERASE: begin
                if (i_stat.erase_last) n_state = r_ret;
            end
            eemf_pkg::S_CP_INIT: n_state = eemf_pkg::S_CP_CHK;
            eemf_pkg::S_CP_CHK: begin
                n_state = i_stat.off_skip ? eemf_pkg::S_CP_NEXT : eemf_pkg::S_CP_RS;
            end
            eemf_pkg::S_CP_RS: n_state = eemf_pkg::S_CP_RD;
            eemf_pkg::S_CP_RD: n_state = eemf_pkg::S_CP_EV;
            eemf_pkg::S_CP_EV: begin
                if (i_stat.copy_diff && !i_stat.q_erased) begin
                    n_state = eemf_pkg::S_ERASE;
                    n_ret   = eemf_pkg::S_CP_INIT;
                end else begin
                    n_state = eemf_pkg::S_CP_NEXT;
                end
            end
            eemf_pkg::S_CP_NEXT: begin
                n_state = i_stat.off_last ? eemf_pkg::S_RL_VALID : eemf_pkg::S_CP_CHK;
            end
            eemf_pkg::S_RL_VALID: n_state = eemf_pkg::S_RL_ESRC;
            eemf_pkg::S_RL_ESRC: begin
                n_state = eemf_pkg::S_ERASE;
                n_ret   = eemf_pkg::S_RL_REMAP;
            end
            eemf_pkg::S_RL_REMAP: begin
                n_state = i_stat.tries_end ? eemf_pkg::S_DONE : eemf_pkg::S_WR_ISSUE;
            end
            eemf_pkg::S_MNT_PAGE: n_state = eemf_pkg::S_MNT_RD;
            eemf_pkg::S_MNT_RD:   n_state = eemf_pkg::S_MNT_EV;
            eemf_pkg::S_MNT_EV: begin
                if (!(i_stat.q_valid && !i_stat.found) && !i_stat.q_erased) begin
                    n_state = eemf_pkg::S_ERASE;
                    n_ret   = eemf_pkg::S_MNT_NEXTM;
                end else begin
                    n_state = eemf_pkg::S_MNT_NEXTM;
                end
            end
            eemf_pkg::S_MNT_NEXTM: begin
                n_state = i_stat.m_last ? eemf_pkg::S_MNT_END : eemf_pkg::S_MNT_RD;
            end
            eemf_pkg::S_MNT_END: begin
                n_state = i_stat.p_last ? eemf_pkg::S_DONE : eemf_pkg::S_MNT_NEXTP;
            end
            eemf_pkg::S_MNT_NEXTP: n_state = eemf_pkg::S_MNT_PAGE;
            eemf_pkg::S_DONE:      n_state = eemf_pkg::S_IDLE;
            default:               n_state = eemf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op    = eemf_pkg::DP_NOP;
        o_busy  = (r_state != eemf_pkg::S_IDLE);
        o_valid = (r_state == eemf_pkg::S_DONE);
        case (r_state)
            eemf_pkg::S_CLEAR: o_op = eemf_pkg::DP_CLR;
            eemf_pkg::S_IDLE: begin
                if (i_start) o_op = eemf_pkg::DP_LOAD;
            end
            eemf_pkg::S_RANGE: begin
                if (i_stat.oor) o_op = eemf_pkg::DP_SET_ERR;
            end
            eemf_pkg::S_DIV: begin
                if (i_stat.rem_ge) o_op = eemf_pkg::DP_DIV_STEP;
                else if (!i_stat.map_ok) o_op = eemf_pkg::DP_SET_ERR;
            end
            eemf_pkg::S_RD_ISSUE: o_op = eemf_pkg::DP_RD_CELL;
            eemf_pkg::S_RD_CAP:   o_op = eemf_pkg::DP_CAP_RDATA;
            eemf_pkg::S_WR_ISSUE: o_op = eemf_pkg::DP_RD_CELL;
            eemf_pkg::S_WR_EVAL: begin
                if (!i_stat.q_eq_din && i_stat.q_erased) o_op = eemf_pkg::DP_WR_CELL;
            end
            eemf_pkg::S_RL_HDR: o_op = eemf_pkg::DP_RD_DHDR;
            eemf_pkg::S_RL_HDR_EV: begin
                if (!i_stat.q_erased) o_op = eemf_pkg::DP_ERASE_INIT_DST;
            end
            eemf_pkg::S_ERASE:   o_op = eemf_pkg::DP_ERASE_STEP;
            eemf_pkg::S_CP_INIT: o_op = eemf_pkg::DP_COPY_INIT;
            eemf_pkg::S_CP_RS:   o_op = eemf_pkg::DP_COPY_RS;
            eemf_pkg::S_CP_RD:   o_op = eemf_pkg::DP_COPY_RD;
            eemf_pkg::S_CP_EV: begin
                if (i_stat.copy_diff) begin
                    if (i_stat.q_erased) o_op = eemf_pkg::DP_COPY_WR;
                    else o_op = eemf_pkg::DP_ERASE_INIT_DST;
                end
            end
            eemf_pkg::S_CP_NEXT: begin
                if (!i_stat.off_last) o_op = eemf_pkg::DP_COPY_NEXT;
            end
            eemf_pkg::S_RL_VALID: o_op = eemf_pkg::DP_DHDR_WR;
            eemf_pkg::S_RL_ESRC:  o_op = eemf_pkg::DP_ERASE_INIT_SRC;
            eemf_pkg::S_RL_REMAP: o_op = eemf_pkg::DP_REMAP;
            eemf_pkg::S_MNT_PAGE: o_op = eemf_pkg::DP_MNT_UNMAP;
            eemf_pkg::S_MNT_RD:   o_op = eemf_pkg::DP_MNT_RD;
            eemf_pkg::S_MNT_EV: begin
                if (i_stat.q_valid && !i_stat.found) o_op = eemf_pkg::DP_MNT_MAP;
                else if (!i_stat.q_erased) o_op = eemf_pkg::DP_ERASE_INIT_MNT;
            end
            eemf_pkg::S_MNT_NEXTM: begin
                if (!i_stat.m_last) o_op = eemf_pkg::DP_MNT_NEXTM;
            end
            eemf_pkg::S_MNT_END: begin
                if (!i_stat.found) o_op = eemf_pkg::DP_MNT_CLAIM;
            end
            eemf_pkg::S_MNT_NEXTP: o_op = eemf_pkg::DP_MNT_NEXTP;
            default: o_op = eemf_pkg::DP_NOP;
        endcase
    end

    `EEMF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `EEMF_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid && !o_busy)
    `EEMF_ASSERT_SAME(a_valid_busy, i_clk, i_rst_n, o_valid, o_busy)
    `EEMF_ASSERT_SAME(a_load_idle, i_clk, i_rst_n, o_op == eemf_pkg::DP_LOAD,
                      !o_busy && i_start)
endmodule
`default_nettype wire

@@ hdl/eeprom_emulation_on_mirrored_flash_top.sv @@
// Top level of the byte EEPROM emulation on mirrored flash pages.
// Depends on eemf_pkg, eemf_ctrl and eemf_dp.
//
// Usage: raise start with a command on i_item while busy is low; the
// transfer happens at that edge. One result follows on o_res, marked by
// o_valid for exactly one cycle; the receiver cannot hold it off, and
// busy stays high until the cycle after the strobe.
// Sequence: a read or write checks the address range, translates it by
// stepping through the pages, then reads the cell; a bad address or an
// unmapped page ends the command with status set. A write programs an
// erased cell in place; else the page moves to the next mirror: the
// destination is erased if needed, the other halfwords are copied, its
// header is marked valid and the source page is erased, then the write is
// retried. Mount scans the mirrors of each page. All steps share the single
// flash port, and items are handled one at a time. Reset: the flash array
// is swept to the erased value, one halfword per cycle, with busy high; all
// pages are unmapped until a mount command.
`default_nettype none
module eeprom_emulation_on_mirrored_flash_top #(
    parameter int PAGE_HALFWORDS = 512,
    parameter int PAGES          = 2,
    parameter int MIRRORS        = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire eemf_pkg::t_in i_item,
    output logic               busy,
    output logic               o_valid,
    output eemf_pkg::t_out     o_res
);
    eemf_pkg::t_dp_op   op;
    eemf_pkg::t_dp_stat stat;

    eemf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    eemf_dp #(
        .PAGE_HALFWORDS (PAGE_HALFWORDS),
        .PAGES          (PAGES),
        .MIRRORS        (MIRRORS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_item  (i_item),
        .o_stat  (stat),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for eeprom_emulation_on_mirrored_flash_top.
// Predicts every command result from a shadow copy of the flash array and page map.
// Depends on eemf_pkg and the RTL under hdl.
`default_nettype none
module tb;
    localparam int PH = 512;
    localparam int NP = 2;
    localparam int NM = 2;
    localparam int DC = PH - 1;
    localparam int FUNC_NONE = 3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    eemf_pkg::t_in  i_item;
    logic busy;
    logic o_valid;
    eemf_pkg::t_out o_res;

    logic [15:0] flash_shadow [NM*NP*PH];
    bit          map_ok [NP];
    int          map_mirror [NP];
    eemf_pkg::t_out pending_results [$];
    int          fails = 0;
    bit          gapless = 0;

    eeprom_emulation_on_mirrored_flash_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_valid(o_valid), .o_res(o_res)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic int page_base(int m, int p);
        return (m * NP + p) * PH;
    endfunction

    function automatic void erase_page(int b);
        for (int i = 0; i < PH; i++) flash_shadow[b + i] = eemf_pkg::HDR_ERASED;
    endfunction

    function automatic bit copy_page(int src, int dst, int skip);
        logic [15:0] din;
        for (int off = 1; off < PH; off++) begin
            if (off == skip) continue;
            din = {eemf_pkg::BYTE_TAG, flash_shadow[src + off][7:0]};
            if (din != flash_shadow[dst + off]) begin
                if (flash_shadow[dst + off] != eemf_pkg::HDR_ERASED) return 1'b0;
                flash_shadow[dst + off] = din;
            end
        end
        return 1'b1;
    endfunction

    function automatic void move_page(int p, int skip);
        int oldm, src, dst;
        oldm = map_mirror[p];
        src = page_base(oldm, p);
        dst = page_base((oldm + 1) % NM, p);
        if (flash_shadow[dst] != eemf_pkg::HDR_ERASED) erase_page(dst);
        if (!copy_page(src, dst, skip)) begin
            erase_page(dst);
            void'(copy_page(src, dst, skip));
        end
        flash_shadow[dst] = eemf_pkg::HDR_VALID;
        erase_page(src);
        map_mirror[p] = (oldm + 1) % NM;
    endfunction

    function automatic void scan_pages();
        bit erased [NM];
        logic [15:0] h;
        for (int p = 0; p < NP; p++) begin
            map_ok[p] = 1'b0;
            for (int m = 0; m < NM; m++) begin
                h = flash_shadow[page_base(m, p)];
                erased[m] = (h == eemf_pkg::HDR_ERASED);
                if (h == eemf_pkg::HDR_VALID && !map_ok[p]) begin
                    map_ok[p] = 1'b1;
                    map_mirror[p] = m;
                end else if (h != eemf_pkg::HDR_ERASED) begin
                    erase_page(page_base(m, p));
                    erased[m] = 1'b1;
                end
            end
            if (!map_ok[p]) begin
                for (int m = 0; m < NM; m++) begin
                    if (erased[m]) begin
                        flash_shadow[page_base(m, p)] = eemf_pkg::HDR_VALID;
                        map_ok[p] = 1'b1;
                        map_mirror[p] = m;
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic eemf_pkg::t_out eeprom_result(eemf_pkg::t_in it);
        eemf_pkg::t_out r;
        int p, off, cell_idx;
        logic [15:0] din;
        r = '0;
        r.last = it.last_byte;
        p = it.address / DC;
        off = it.address % DC + 1;
        if (it.func == eemf_pkg::FUNC_MOUNT) begin
            scan_pages();
        end else if (it.func == eemf_pkg::FUNC_READ || it.func == eemf_pkg::FUNC_WRITE) begin
            if (it.address >= NP * DC || !map_ok[p]) begin
                r.status = 1'b1;
            end else if (it.func == eemf_pkg::FUNC_READ) begin
                r.read_data = flash_shadow[page_base(map_mirror[p], p) + off][7:0];
            end else begin
                din = {eemf_pkg::BYTE_TAG, it.write_data};
                for (int t = 0; t <= NM + 1; t++) begin
                    cell_idx = page_base(map_mirror[p], p) + off;
                    if (flash_shadow[cell_idx] == din) break;
                    if (flash_shadow[cell_idx] == eemf_pkg::HDR_ERASED) begin
                        flash_shadow[cell_idx] = din;
                        break;
                    end
                    move_page(p, off);
                    r.relocated = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic send_cmd(int func, int addr, int data, bit lastb);
        int gap;
        if (gapless) gap = 0;
        else if ($urandom_range(99) < 60) gap = 0;
        else if ($urandom_range(99) < 85) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= '{func: func[1:0], address: addr[9:0], write_data: data[7:0],
                    last_byte: lastb};
        do @(posedge i_clk); while (busy);
        pending_results.push_back(eeprom_result(i_item));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        eemf_pkg::t_out exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result with no command outstanding");
                fails++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_res.read_data !== exp_r.read_data) begin
                    $error("read_data exp %0h got %0h", exp_r.read_data, o_res.read_data);
                    fails++;
                end
                if (o_res.status !== exp_r.status) begin
                    $error("status exp %0b got %0b", exp_r.status, o_res.status);
                    fails++;
                end
                if (o_res.relocated !== exp_r.relocated) begin
                    $error("relocated exp %0b got %0b", exp_r.relocated, o_res.relocated);
                    fails++;
                end
                if (o_res.last !== exp_r.last) begin
                    $error("last exp %0b got %0b", exp_r.last, o_res.last);
                    fails++;
                end
            end
        end
    end

    task automatic test_unmounted();
        send_cmd(eemf_pkg::FUNC_READ, 0, 0, 1);
        send_cmd(eemf_pkg::FUNC_WRITE, 1021, 8'hFF, 0);
        send_cmd(FUNC_NONE, 1023, 8'h00, 1);
    endtask

    task automatic test_mount_and_range();
        send_cmd(eemf_pkg::FUNC_MOUNT, 0, 0, 0);
        send_cmd(eemf_pkg::FUNC_READ, 1021, 0, 1);
        send_cmd(eemf_pkg::FUNC_READ, 1022, 0, 0);
        send_cmd(eemf_pkg::FUNC_WRITE, 1023, 8'hAA, 1);
        send_cmd(eemf_pkg::FUNC_WRITE, 0, 8'h00, 0);
        send_cmd(eemf_pkg::FUNC_WRITE, 510, 8'hFF, 0);
        send_cmd(eemf_pkg::FUNC_WRITE, 511, 8'h55, 1);
        send_cmd(eemf_pkg::FUNC_WRITE, 1021, 8'hFF, 1);
        send_cmd(eemf_pkg::FUNC_READ, 0, 0, 0);
        send_cmd(eemf_pkg::FUNC_READ, 511, 0, 1);
        send_cmd(FUNC_NONE, 0, 8'hFF, 0);
    endtask

    task automatic test_relocation();
        send_cmd(eemf_pkg::FUNC_WRITE, 5, 8'h12, 0);
        send_cmd(eemf_pkg::FUNC_WRITE, 5, 8'h12, 0);
        send_cmd(eemf_pkg::FUNC_WRITE, 5, 8'h34, 1);
        send_cmd(eemf_pkg::FUNC_READ, 5, 0, 0);
        send_cmd(eemf_pkg::FUNC_READ, 0, 0, 1);
        send_cmd(eemf_pkg::FUNC_WRITE, 511, 8'hC3, 0);
        send_cmd(eemf_pkg::FUNC_READ, 511, 0, 1);
        drain();
        send_cmd(eemf_pkg::FUNC_MOUNT, 0, 0, 1);
        send_cmd(eemf_pkg::FUNC_READ, 5, 0, 1);
    endtask

    task automatic test_random(int n);
        int r, a, d, p;
        bit [9:0] written [$];
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) gapless = ($urandom_range(2) == 0);
            if (i == n / 2) drain();
            r = $urandom_range(99);
            a = $urandom_range(NP * DC - 1);
            if ($urandom_range(99) < 3) a = $urandom_range(NP * DC, 1023);
            d = $urandom_range(255);
            if (r < 40) begin
                if (written.size() != 0 && r < 20) a = written[$urandom_range(written.size()-1)];
                send_cmd(eemf_pkg::FUNC_READ, a, d, $urandom_range(1));
            end else if (r < 94) begin
                if (written.size() != 0 && r < 50) begin
                    a = written[$urandom_range(written.size()-1)];
                    p = a / DC;
                    if ($urandom_range(3) != 0 && map_ok[p])
                        d = flash_shadow[page_base(map_mirror[p], p) + a % DC + 1][7:0];
                end
                written.push_back(a[9:0]);
                send_cmd(eemf_pkg::FUNC_WRITE, a, d, $urandom_range(1));
            end else if (r < 97) begin
                send_cmd(eemf_pkg::FUNC_MOUNT, a, d, $urandom_range(1));
            end else begin
                send_cmd(FUNC_NONE, a, d, $urandom_range(1));
            end
        end
        gapless = 0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        foreach (flash_shadow[i]) flash_shadow[i] = eemf_pkg::HDR_ERASED;
        foreach (map_ok[i]) begin
            map_ok[i] = 1'b0;
            map_mirror[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unmounted();
        test_mount_and_range();
        test_relocation();
        test_random(1600);
        drain();
        repeat (50) @(posedge i_clk);
        if (fails == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end

    initial begin
        #2_000_000_000;
        $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/eemf_pkg.sv
hdl/eemf_ram.sv
hdl/eemf_dp.sv
hdl/eemf_ctrl.sv
hdl/eeprom_emulation_on_mirrored_flash_top.sv
test/tb.sv
